@@ rtl/fir_mc_pkg.sv @@
package fir_mc_pkg;

  localparam int SampleW    = 16;
  localparam int WeightW    = 16;
  localparam int ChanW      = 3;
  localparam int OutW       = 21;
  localparam int OutTdataW  = 24;
  localparam int MaxTaps    = 8;
  localparam int WeightIdxW = 3;
  localparam int CfgIdxW    = 4;
  localparam int ProdW      = SampleW + WeightW;
  localparam int PairCount  = MaxTaps / 2;
  localparam int PairW      = ProdW + 1;
  localparam int SumW       = ProdW + 3;
  localparam int FracShift  = 14;

  // 1.0 in Q2.14
  localparam logic [WeightW-1:0] WeightOne = 16'h4000;

  typedef logic [MaxTaps-1:0][SampleW-1:0] window_t;
  typedef logic [MaxTaps-1:0][WeightW-1:0] weights_t;

endpackage

@@ rtl/fir_mc_dot.sv @@
module fir_mc_dot import fir_mc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ChanW-1:0]       in_chan_i,
  input  window_t                window_i,
  input  weights_t               weight_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ChanW-1:0]       out_chan_o,
  output logic signed [OutW-1:0] out_value_o
);

  logic signed [ProdW-1:0] prod [MaxTaps];
  logic signed [PairW-1:0] pair_d [PairCount];
  logic signed [PairW-1:0] pair_q [PairCount];
  logic signed [SumW-1:0]  sum;

  logic                   p_vld_q;
  logic [ChanW-1:0]       p_chan_q;
  logic                   o_vld_q;
  logic [ChanW-1:0]       o_chan_q;
  logic signed [OutW-1:0] o_value_q;

  logic o_ready;
  logic p_adv;
  logic in_fire;

  assign o_ready    = !o_vld_q || out_ready_i;
  assign p_adv      = p_vld_q && o_ready;
  assign in_ready_o = !p_vld_q || o_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  // products and first adder level
  always_comb begin
    for (int k = 0; k < MaxTaps; k++) begin
      prod[k] = $signed(window_i[k]) * $signed(weight_i[k]);
    end
    for (int j = 0; j < PairCount; j++) begin
      pair_d[j] = PairW'(prod[2*j]) + PairW'(prod[2*j+1]);
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < PairCount; j++) begin
      sum = sum + SumW'(pair_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        p_vld_q <= 1'b1;
      end else if (p_adv) begin
        p_vld_q <= 1'b0;
      end
      if (p_adv) begin
        o_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        o_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_chan_q <= in_chan_i;
      pair_q   <= pair_d;
    end
    if (p_adv) begin
      o_chan_q  <= p_chan_q;
      o_value_q <= sum[SumW-1:FracShift];
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_chan_o  = o_chan_q;
  assign out_value_o = o_value_q;

endmodule

@@ rtl/fir_filter_multichannel.sv @@
// A result word passes three register stages, the delay-line stage, the pair
// register and the output register, before a receiver can take it.
// Throughput: one word per cycle, sustained in any channel order unless output stalls.
// The per-channel history lives in a one-read one-write memory; a same-channel
// word right behind another takes the freshly written history through a bypass.
// Reset: weights return to a unit impulse (weight_0 = 1.0), per-channel valid
// bits make every delay line read as zero; no clearing pass is needed.
module fir_filter_multichannel import fir_mc_pkg::*; #(
  parameter int CHANNELS = 8,
  parameter int TAPS     = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SampleW-1:0]   s_axis_tdata,   // [15:0] sample_in
  input  logic [ChanW-1:0]     s_axis_tuser,   // [2:0] channel
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [20:0] filtered, [23:21] zero
  output logic [ChanW-1:0]     m_axis_tuser,   // [2:0] channel_out
  // weight write port
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [WeightW-1:0]   cfg_data_i
);

  // history kept per channel: every sample but the newest one
  localparam int HistLen = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int AddrW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef logic [HistLen-1:0][SampleW-1:0] hist_t;

  // fold the channel number into range
  function automatic logic [ChanW-1:0] chan_wrap(input logic [ChanW-1:0] c);
    int v;
    v = int'(c);
    for (int i = 0; i < (1 << ChanW); i++) begin
      if (v >= CHANNELS) v = v - CHANNELS;
    end
    return ChanW'(v);
  endfunction

  logic               s_accept;
  logic [ChanW-1:0]   in_chan;
  logic [AddrW-1:0]   in_addr;

  // delay-line stage
  logic               s1_vld_q;
  logic [ChanW-1:0]   s1_chan_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               byp_q;
  hist_t              byp_row_q;
  logic               rd_vld_q;
  hist_t              mem_rd_q;
  logic [AddrW-1:0]   s1_addr;
  logic               s1_fire;
  logic               byp_d;
  hist_t              hist_cur;
  hist_t              hist_new;
  window_t            window;

  hist_t              hist_mem [CHANNELS];
  logic [CHANNELS-1:0] row_vld_q;

  logic [WeightW-1:0] weight_q [MaxTaps];
  weights_t           weights;

  logic                   dot_ready;
  logic signed [OutW-1:0] filtered;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_chan       = chan_wrap(s_axis_tuser);
  assign in_addr       = AddrW'(in_chan);
  assign s1_addr       = AddrW'(s1_chan_q);
  assign s1_fire       = s1_vld_q && dot_ready;
  assign s_axis_tready = !s1_vld_q || dot_ready;

  // the word ahead writes this channel at the same edge: take its row directly
  assign byp_d = s1_fire && (s1_chan_q == in_chan);

  // a row never written reads as silence
  assign hist_cur = byp_q ? byp_row_q : (rd_vld_q ? mem_rd_q : '0);

  // shift the history by one, newest sample at the front
  always_comb begin
    hist_new[0] = s1_sample_q;
    for (int j = 1; j < HistLen; j++) begin
      hist_new[j] = hist_cur[j-1];
    end
  end

  // tap window; taps past TAPS see zero
  for (genvar k = 0; k < MaxTaps; k++) begin : g_win
    if (k == 0) begin : g_new
      assign window[k] = s1_sample_q;
    end else if (k < TAPS) begin : g_old
      assign window[k] = hist_cur[k-1];
    end else begin : g_off
      assign window[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      row_vld_q <= '0;
    end else begin
      if (s_accept) begin
        s1_vld_q <= 1'b1;
        byp_q    <= byp_d;
        rd_vld_q <= row_vld_q[in_addr];
      end else if (s1_fire) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_fire) begin
        row_vld_q[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_chan_q   <= in_chan;
      s1_sample_q <= s_axis_tdata;
      byp_row_q   <= hist_new;
    end
  end

  // history memory: write back on advance, read on accept
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      hist_mem[s1_addr] <= hist_new;
    end
    if (s_accept) begin
      mem_rd_q <= hist_mem[in_addr];
    end
  end

  // weight registers; writes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxTaps; k++) begin
        weight_q[k] <= (k == 0) ? WeightOne : '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(MaxTaps))) begin
      weight_q[cfg_index_i[WeightIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int k = 0; k < MaxTaps; k++) begin
      weights[k] = weight_q[k];
    end
  end

  assign cfg_ready_o = 1'b1;

  fir_mc_dot u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_vld_q),
    .in_ready_o  (dot_ready),
    .in_chan_i   (s1_chan_q),
    .window_i    (window),
    .weight_i    (weights),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_chan_o  (m_axis_tuser),
    .out_value_o (filtered)
  );

  assign m_axis_tdata = {{(OutTdataW - OutW){1'b0}}, filtered};

endmodule

@@ rtl/fir_mc_checker.sv @@
module fir_mc_checker import fir_mc_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [ChanW-1:0]     m_axis_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // input stalls only behind a waiting result
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OutTdataW-1:OutW] == '0))
    else $error("padding bits of result word not zero");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tuser) < CHANNELS))
    else $error("result channel out of range");

endmodule

bind fir_filter_multichannel fir_mc_checker #(
  .CHANNELS (CHANNELS)
) u_fir_mc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fir_mc_pkg::*;

  localparam int Channels      = 8;
  localparam int Taps          = 8;
  localparam int Phases        = 10;
  localparam int WordsPerPhase = 100;
  localparam int HoldPhase     = 3;
  localparam int HoldCycles    = 300;
  localparam int TailCycles    = 12;
  localparam int Limit         = 200000;

  // Register map: weight_k sits at index k, anything past the last weight is ignored
  localparam logic [CfgIdxW-1:0] RegWeight0 = '0;
  localparam logic [CfgIdxW-1:0] RegPastEnd = CfgIdxW'(MaxTaps);

  localparam logic [WeightW-1:0] WeightMax = 16'h7FFF;
  localparam logic [WeightW-1:0] WeightMin = 16'h8000;
  localparam logic [SampleW-1:0] SampleMax = 16'h7FFF;
  localparam logic [SampleW-1:0] SampleMin = 16'h8000;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [OutW-1:0]  filtered;
  } fir_out_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_SET_ONE, ROW_SET_ALL} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] reg_idx;
    logic [WeightW-1:0] reg_val;
    logic [ChanW-1:0]   chan;
    logic [SampleW-1:0] smp;
    logic               known;   // want holds the filtered value typed in by hand
    logic [OutW-1:0]    want;
  } plan_row_t;

  // Directed opening: unit impulse after reset, ignored register write, full-scale
  // windows with both weight extremes, floor rounding of negative sums, averaging.
  localparam int PlanLen = 26;
  localparam plan_row_t Plan [PlanLen] = '{
    '{ROW_WORD,    '0,         '0,       3'd0, 16'h7FFF, 1'b1, 21'h007FFF},
    '{ROW_WORD,    '0,         '0,       3'd7, 16'h8000, 1'b1, 21'h1F8000},
    '{ROW_WORD,    '0,         '0,       3'd3, 16'hFFFF, 1'b1, 21'h1FFFFF},
    '{ROW_WORD,    '0,         '0,       3'd0, 16'h0000, 1'b1, 21'h000000},
    '{ROW_SET_ONE, RegPastEnd, 16'h1234, 3'd0, '0,       1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd5, 16'h0001, 1'b1, 21'h000001},
    '{ROW_SET_ALL, '0,         WeightMin, 3'd0, '0,      1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b1, 21'h010000},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b1, 21'h080000},
    '{ROW_SET_ALL, '0,         WeightMax, 3'd0, '0,      1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd1, 16'h8000, 1'b1, 21'h180010},
    '{ROW_WORD,    '0,         '0,       3'd6, 16'h7FFF, 1'b0, '0},
    '{ROW_SET_ALL, '0,         16'h0000, 3'd0, '0,       1'b0, '0},
    '{ROW_SET_ONE, RegWeight0, 16'h0001, 3'd0, '0,       1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd2, 16'hFFFF, 1'b1, 21'h1FFFFF},
    '{ROW_WORD,    '0,         '0,       3'd2, 16'h0001, 1'b1, 21'h000000},
    '{ROW_SET_ALL, '0,         16'h0800, 3'd0, '0,       1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd4, 16'h1234, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd4, 16'hEDCB, 1'b0, '0},
    '{ROW_WORD,    '0,         '0,       3'd2, 16'h4000, 1'b0, '0}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SampleW-1:0]   s_axis_tdata  = '0;   // [15:0] sample_in
  logic [ChanW-1:0]     s_axis_tuser  = '0;   // [2:0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;         // [20:0] filtered, [23:21] zero
  logic [ChanW-1:0]     m_axis_tuser;         // [2:0] channel_out
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [WeightW-1:0]   cfg_data_i    = '0;

  // Own copy of the filter: weights and per-channel sample history, newest in slot 0
  logic signed [WeightW-1:0] coef [MaxTaps];
  logic signed [SampleW-1:0] hist [Channels][MaxTaps];

  fir_out_t         pending_out [$];   // filtered words still owed by the block
  fir_out_t         head;
  logic [ChanW-1:0] cur_chan      = '0;
  logic             calm          = 1'b0;  // no idling on either side
  logic             hold_req      = 1'b0;  // ask the receiver for one long hold-off
  int               errors        = 0;
  int               words_in      = 0;
  int               words_out     = 0;
  int               weight_writes = 0;
  int               cycles        = 0;

  fir_filter_multichannel #(
    .CHANNELS(Channels),
    .TAPS    (Taps)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Push the sample into its channel's history, then form the Q2.14 weighted sum
  // and floor it by the fraction width; the result always fits in OutW bits.
  function automatic fir_out_t filter_step(input logic [ChanW-1:0] ch,
                                           input logic [SampleW-1:0] x);
    fir_out_t         r;
    logic [ChanW-1:0] c;
    longint           acc;
    int               k;
    c = ChanW'(ch % Channels);
    for (k = Taps - 1; k > 0; k--) hist[c][k] = hist[c][k-1];
    hist[c][0] = x;
    acc = 0;
    for (k = 0; k < Taps && k < MaxTaps; k++) begin
      acc += longint'(coef[k]) * longint'(hist[c][k]);
    end
    r.chan     = c;
    r.filtered = OutW'(acc >>> FracShift);
    return r;
  endfunction

  // Offer one word and hold it until taken; record what the block owes for it.
  // Valid stays high on return unless a random gap follows.
  task automatic send_word(input logic [ChanW-1:0] ch, input logic [SampleW-1:0] x,
                           input logic known, input logic [OutW-1:0] want);
    fir_out_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    r = filter_step(ch, x);
    if (known) r.filtered = want;
    pending_out.push_back(r);
    words_in++;
    if (!calm && $urandom_range(0, 7) == 0) begin
      // idle burst with junk on the bus
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= SampleW'($urandom);
      s_axis_tuser  <= ChanW'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every owed word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  // One register write; valid drops again before the task returns, keeping valid edges apart
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WeightW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < MaxTaps) coef[idx[WeightIdxW-1:0]] = val;
    weight_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_words(input int n);
    int                 i;
    logic [SampleW-1:0] x;
    for (i = 0; i < n; i++) begin
      // stay on the same channel a third of the time to hit back-to-back history reuse
      if ($urandom_range(0, 2) != 0) cur_chan = ChanW'($urandom_range(0, Channels - 1));
      case ($urandom_range(0, 9))
        0: x = SampleMax;
        1: x = SampleMin;
        2: x = '0;
        3: x = '1;
        default: x = SampleW'($urandom);
      endcase
      send_word(cur_chan, x, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none when calm
  initial begin : rx_side
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each delivered word with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (pending_out.size() == 0) begin
        $error("unexpected word: channel_out %0d filtered %h", m_axis_tuser,
               m_axis_tdata[OutW-1:0]);
        errors++;
      end else begin
        head = pending_out.pop_front();
        if (m_axis_tuser !== head.chan) begin
          $error("channel_out: expected %0d, got %0d", head.chan, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[OutW-1:0] !== head.filtered) begin
          $error("filtered: expected %h, got %h", head.filtered, m_axis_tdata[OutW-1:0]);
          errors++;
        end
        if (m_axis_tdata[OutTdataW-1:OutW] !== '0) begin
          $error("tdata padding: expected 0, got %h", m_axis_tdata[OutTdataW-1:OutW]);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin : stim
    int                 i;
    int                 k;
    int                 ph;
    int                 cut;
    plan_row_t          row;
    logic [WeightW-1:0] w;
    // reset state: unit impulse, empty histories
    for (k = 0; k < MaxTaps; k++) coef[k] = (k == 0) ? WeightOne : '0;
    for (i = 0; i < Channels; i++) begin
      for (k = 0; k < MaxTaps; k++) hist[i][k] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < PlanLen; i++) begin
      row = Plan[i];
      case (row.kind)
        ROW_WORD: begin
          send_word(row.chan, row.smp, row.known, row.want);
        end
        ROW_SET_ONE: begin
          drain();
          write_reg(row.reg_idx, row.reg_val);
        end
        ROW_SET_ALL: begin
          drain();
          for (k = 0; k < MaxTaps; k++) write_reg(CfgIdxW'(RegWeight0 + k), row.reg_val);
        end
        default: ;
      endcase
    end

    // Random part: a fresh weight setting per phase, first the two extremes, then
    // random sets with a random filter length (zero trailing weights)
    for (ph = 0; ph < Phases; ph++) begin
      drain();
      calm = (ph == Phases - 1);
      cut  = (ph < 2) ? MaxTaps : $urandom_range(1, MaxTaps);
      for (k = 0; k < MaxTaps; k++) begin
        case (ph)
          0: w = WeightMax;
          1: w = WeightMin;
          default: begin
            if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 1) ? WeightMax : WeightMin;
            else w = WeightW'($urandom);
          end
        endcase
        if (k >= cut) w = '0;
        // leave some weights untouched from the previous phase
        if (ph < 2 || k >= cut || $urandom_range(0, 3) != 0) begin
          write_reg(CfgIdxW'(RegWeight0 + k), w);
        end
      end
      write_reg(CfgIdxW'($urandom_range(MaxTaps, (1 << CfgIdxW) - 1)), WeightW'($urandom));
      // long output hold-off while words keep coming, so the input backs up
      if (ph == HoldPhase) hold_req = 1'b1;
      random_words(WordsPerPhase);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Filtered %0d of %0d words across %0d channels, %0d register writes.",
             words_out, words_in, Channels, weight_writes);
    $display("Covered impulse reset, extreme weights and samples, floor rounding, %s",
             "ignored indexes, short filters and a long output hold-off.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fir_mc_pkg.sv
rtl/fir_mc_dot.sv
rtl/fir_filter_multichannel.sv
rtl/fir_mc_checker.sv
verif/testbench.sv
